// ===== sv/pcg32_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg32_pkg
// Shared types and constants of the PCG32 XSH-RR generator.
// ----------------------------------------------------------------------------
package pcg32_pkg;

  localparam logic [1:0] KIND_RESEED   = 2'd0;
  localparam logic [1:0] KIND_RAW      = 2'd1;
  localparam logic [1:0] KIND_URANGE   = 2'd2;
  localparam logic [1:0] KIND_SRANGE   = 2'd3;

  localparam logic [63:0] LCG_MULT     = 64'h5851_F42D_4C95_7F2D;
  localparam int unsigned XSH_SHIFT    = 18;
  localparam int unsigned OUT_SHIFT    = 27;
  localparam int unsigned ROT_LSB      = 59;
  localparam int unsigned DIV_STEPS    = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] first_operand;
    logic [63:0] second_operand;
  } pcg32_req_t;

  typedef struct packed {
    logic [31:0] random_value;
    logic        range_error;
  } pcg32_rsp_t;

  typedef struct packed {
    logic capture;
    logic seed;
    logic mul0;
    logic mul1;
    logic mul2;
    logic mul3;
    logic upd;
    logic div_init;
    logic div_step;
  } pcg32_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic is_range;
    logic range_err;
    logic div_last;
  } pcg32_sts_t;

endpackage

// ===== sv/pcg32_datapath.sv =====
// ----------------------------------------------------------------------------
// pcg32_datapath
// LCG state, shared 32x32 multiplier, output permutation and bit-serial
// remainder unit.
// ----------------------------------------------------------------------------
module pcg32_datapath
  import pcg32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pcg32_req_t req_i,
  input  pcg32_cmd_t cmd_i,
  output pcg32_sts_t sts_o,
  output pcg32_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  pcg32_req_t     req_q;
  logic [63:0]    state_q, state_d;
  logic [63:0]    inc_q, inc_d;
  logic [63:0]    prod_q;
  logic [63:0]    acc_q, acc_d;
  logic [31:0]    raw_q;
  logic [31:0]    dvd_q;
  logic [32:0]    rem_q;
  logic [32:0]    span_q;
  logic [CntW-1:0] cnt_q;

  logic [31:0] lo32, hi32;
  logic [31:0] xsh;
  logic [4:0]  rot;
  logic [63:0] rot_w;
  logic [31:0] perm;
  logic [31:0] op_a, op_b;
  logic [32:0] rem_sh;
  logic [32:0] span_d;

  assign lo32 = req_q.first_operand[31:0];
  assign hi32 = req_q.second_operand[31:0];

  // XSH-RR permutation of the current (old) state
  assign xsh   = 32'(((state_q >> XSH_SHIFT) ^ state_q) >> OUT_SHIFT);
  assign rot   = state_q[63:ROT_LSB];
  assign rot_w = {xsh, xsh} >> rot;
  assign perm  = rot_w[31:0];

  // low 64 bits of state * mult from three partial products
  assign op_a = cmd_i.mul2 ? state_q[63:32] : state_q[31:0];
  assign op_b = cmd_i.mul1 ? LCG_MULT[63:32] : LCG_MULT[31:0];

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul1) begin
      acc_d = prod_q;
    end else if (cmd_i.mul2 || cmd_i.mul3) begin
      acc_d = acc_q + {prod_q[31:0], 32'd0};
    end
  end

  always_comb begin
    state_d = state_q;
    inc_d   = inc_q;
    if (cmd_i.seed) begin
      inc_d   = {req_q.second_operand[62:0], 1'b1};
      state_d = inc_d + req_q.first_operand;
    end else if (cmd_i.upd) begin
      state_d = acc_q + inc_q;
    end
  end

  assign span_d = {1'b0, hi32 - lo32} + 33'd1;
  assign rem_sh = {rem_q[31:0], dvd_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      inc_q   <= 64'd1;
    end else begin
      state_q <= state_d;
      inc_q   <= inc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.mul0 || cmd_i.mul1 || cmd_i.mul2) begin
      prod_q <= {32'd0, op_a} * {32'd0, op_b};
    end
    acc_q <= acc_d;
    if (cmd_i.mul0) begin
      raw_q <= perm;
    end
    if (cmd_i.div_init) begin
      dvd_q  <= raw_q;
      rem_q  <= '0;
      span_q <= span_d;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= (rem_sh >= span_q) ? rem_sh - span_q : rem_sh;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    sts_o.is_seed  = (req_q.kind == KIND_RESEED);
    sts_o.is_range = req_q.kind[1];
    sts_o.div_last = (cnt_q == CntW'(DIV_STEPS - 1));
    unique case (req_q.kind)
      KIND_URANGE: sts_o.range_err = (hi32 <= lo32);
      KIND_SRANGE: sts_o.range_err = ($signed(hi32) <= $signed(lo32));
      default:     sts_o.range_err = 1'b0;
    endcase
  end

  always_comb begin
    rsp_o.range_error = sts_o.range_err;
    unique case (req_q.kind)
      KIND_RESEED: rsp_o.random_value = '0;
      KIND_RAW:    rsp_o.random_value = raw_q;
      default:     rsp_o.random_value = sts_o.range_err ? '0 : rem_q[31:0] + lo32;
    endcase
  end

endmodule

// ===== sv/pcg32_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcg32_ctrl
// Request sequencer: check, multiply phases, state update, remainder, result.
// ----------------------------------------------------------------------------
module pcg32_ctrl
  import pcg32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  pcg32_sts_t sts_i,
  output pcg32_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_MUL3  = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.seed = sts_i.is_seed;
        state_d    = sts_i.range_err ? S_OUT : S_MUL0;
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd      = 1'b1;
        cmd_o.div_init = sts_i.is_range;
        state_d        = sts_i.is_range ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pcg32_random_generator.sv =====
// ----------------------------------------------------------------------------
// pcg32_random_generator
// PCG32 XSH-RR generator with reseed, raw and range requests.
// ----------------------------------------------------------------------------
// channel  | signals                       | payload
// ---------+-------------------------------+-------------
// request  | in_valid_i / in_ready_o       | in_data_i
// result   | out_valid_o / out_ready_i     | out_data_o
//
// One request at a time. Raw and reseed requests pass through the check, the
// multiply states S_MUL0 to S_MUL3 and the state update before result valid
// rises; range requests add the bit-serial remainder, and a rejected range
// request goes from the check straight to the result.
// The 64-bit state update uses one shared 32x32 multiplier over three phases.
// Reset loads state 0 and increment 1. A stalled result holds until transfer;
// no request is taken meanwhile.
// ----------------------------------------------------------------------------
module pcg32_random_generator
  import pcg32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pcg32_req_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pcg32_rsp_t out_data_o
);

  pcg32_cmd_t cmd;
  pcg32_sts_t sts;

  // sequence the request
  pcg32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold state, multiply, permute and reduce
  pcg32_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );

`ifndef SYNTH
  // never take a request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("request taken while result pending");
  // a rejected range reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.range_error) |-> (out_data_o.random_value == '0))
    else $error("range error with nonzero value");
  // a waiting result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/tb_pcg32_random_generator.sv =====
// ----------------------------------------------------------------------------
// tb_pcg32_random_generator
// Self-checking bench for the PCG32 generator: a local predictor computes each
// expected value from its own copy of the LCG state; results are compared in
// order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_pcg32_random_generator;
  import pcg32_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       req_valid;
  logic       req_ready;
  pcg32_req_t req_data;
  logic       rsp_valid;
  logic       rsp_ready;
  pcg32_rsp_t rsp_data;

  // Predictor state and queue of expected results
  logic [63:0] lcg_state;
  logic [63:0] lcg_inc;
  pcg32_rsp_t  pending_rsp[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  pcg32_random_generator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_data_o (rsp_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Advance the LCG and return the XSH-RR permutation of the old state
  function automatic logic [31:0] lcg_advance();
    logic [63:0] old;
    logic [31:0] x;
    logic [4:0]  r;
    old       = lcg_state;
    lcg_state = old * LCG_MULT + lcg_inc;
    x         = 32'(((old >> XSH_SHIFT) ^ old) >> OUT_SHIFT);
    r         = old[63:59];
    return (x >> r) | (x << ((32 - r) & 31));
  endfunction

  function automatic pcg32_rsp_t predict_pcg(pcg32_req_t req);
    pcg32_rsp_t  rsp;
    logic [31:0] lo32, hi32, span32, raw;
    logic signed [63:0] slo, shi;
    logic [63:0] span64;
    rsp  = '0;
    lo32 = req.first_operand[31:0];
    hi32 = req.second_operand[31:0];
    case (req.kind)
      KIND_RESEED: begin
        lcg_inc   = {req.second_operand[62:0], 1'b1};
        lcg_state = '0;
        void'(lcg_advance());
        lcg_state = lcg_state + req.first_operand;
        void'(lcg_advance());
      end
      KIND_RAW: rsp.random_value = lcg_advance();
      KIND_URANGE: begin
        if (hi32 <= lo32) begin
          rsp.range_error = 1'b1;
        end else begin
          span32 = hi32 - lo32 + 32'd1;
          raw    = lcg_advance();
          rsp.random_value = (span32 == 0) ? raw + lo32 : raw % span32 + lo32;
        end
      end
      default: begin
        slo = 64'(signed'(lo32));
        shi = 64'(signed'(hi32));
        if (shi <= slo) begin
          rsp.range_error = 1'b1;
        end else begin
          span64 = 64'(shi - slo) + 64'd1;
          raw    = lcg_advance();
          rsp.random_value = 32'((64'(raw) % span64) + 64'(slo));
        end
      end
    endcase
    return rsp;
  endfunction

  // Hold the request until transfer, after a random gap
  task automatic send_req(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
    int unsigned gap;
    pcg32_req_t  req;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req = '{kind: kind, first_operand: a, second_operand: b};
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(predict_pcg(req));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Pick an edge-ish 32-bit value
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_req(KIND_RAW, '0, '0);
    send_req(KIND_RAW, '1, '1);
    send_req(KIND_RESEED, 64'd42, 64'd54);
    send_req(KIND_RAW, '0, '0);
    send_req(KIND_RESEED, '1, '1);
    send_req(KIND_RAW, '0, '0);
    send_req(KIND_URANGE, 64'd0, 64'hFFFF_FFFF);             // full span wraps
    send_req(KIND_URANGE, 64'd5, 64'd5);                     // max == min
    send_req(KIND_URANGE, 64'd9, 64'd3);                     // max < min
    send_req(KIND_URANGE, 64'd1, 64'hFFFF_FFFF);
    send_req(KIND_URANGE, 64'hFFFF_FFFF_0000_0003, 64'hABCD_0000_0000_0007);
    send_req(KIND_SRANGE, 64'h8000_0000, 64'h7FFF_FFFF);     // widest signed span
    send_req(KIND_SRANGE, 64'h7FFF_FFFF, 64'h8000_0000);     // signed reject
    send_req(KIND_SRANGE, 64'hFFFF_FFFF, 64'h0);             // -1 .. 0
    send_req(KIND_SRANGE, 64'h0, 64'hFFFF_FFFF);             // 0 > -1: reject
    send_req(KIND_SRANGE, 64'h1234_5678_FFFF_FFF0, 64'hFFFF_0000_0000_0010);
    send_req(KIND_RESEED, '0, '0);
    send_req(KIND_RAW, '0, '0);
  endtask

  task automatic test_random(int unsigned n);
    logic [1:0]  kind;
    logic [63:0] a, b;
    repeat (n) begin
      kind = 2'($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 3));
      if (kind == KIND_RESEED) begin
        a = rand64();
        b = rand64();
      end else begin
        a = {$urandom(), pick32()};
        b = {$urandom(), pick32()};
        // Mostly valid ranges, so the state keeps advancing
        if ($urandom_range(0, 4) != 0 && a[31:0] != b[31:0]) begin
          if (kind == KIND_URANGE && b[31:0] < a[31:0]) {a, b} = {b, a};
          if (kind == KIND_SRANGE && signed'(b[31:0]) < signed'(a[31:0]))
            {a, b} = {b, a};
        end
      end
      send_req(kind, a, b);
    end
  endtask

  // Result side: stall at random, compare each transfer in order
  initial begin
    int unsigned stall;
    rsp_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        rsp_ready <= 1'b0;
        @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", rsp_data);
      end else begin
        pcg32_rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp_data.random_value !== want.random_value ||
            rsp_data.range_error !== want.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, error exp %b got %b",
                     want.random_value, rsp_data.random_value,
                     want.range_error, rsp_data.range_error);
        end
      end
    end
  end

  // Watchdog: drop the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pcg32_random_generator: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned drain;
    lcg_state   = '0;
    lcg_inc     = 64'd1;
    rst_n       = 1'b0;
    req_valid   = 1'b0;
    req_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1930);
    req_valid <= 1'b0;
    drain = 0;
    while (pending_rsp.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("tb_pcg32_random_generator: PASS");
    else
      $display("tb_pcg32_random_generator: FAIL");
    $finish;
  end

endmodule
